/* sv/utc_pkg.sv */
// utc_pkg: shared types, fixed-point constants and tables for the unicycle
// tracking controller. No dependencies; imported by every module of the block.
package utc_pkg;

  typedef logic signed [27:0] ang_t;   // CORDIC angle, Q.24 rad
  typedef logic signed [33:0] trig_t;  // sine / cosine, Q.30
  typedef logic [30:0] sinc_t;         // sinc value, unsigned Q.30
  typedef logic [1:0] cfg_idx_t;

  localparam int CORDIC_MAX = 24;
  localparam int SINC_TERMS = 4;
  localparam int SINC_LAT   = 12;

  localparam ang_t ANG_PI      = 28'sd52707179;
  localparam ang_t ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [16:0] HEAD_PI     = 17'sd25736;
  localparam logic signed [16:0] HEAD_TWO_PI = 17'sd51472;
  localparam trig_t INV_GAIN = 34'sd652032874;
  localparam sinc_t ONE_Q30  = 31'd1073741824;

  localparam ang_t ATAN_Q24 [0:CORDIC_MAX-1] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384,
    28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
    28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  // Series divisors and floor(2^32 / d) reciprocals
  localparam logic [6:0]  SINC_DIV   [0:SINC_TERMS-1] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] SINC_RECIP [0:SINC_TERMS-1] =
    '{32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};

  localparam cfg_idx_t CFG_GAIN_POSITION = 2'd0;
  localparam cfg_idx_t CFG_GAIN_HEADING  = 2'd1;
  localparam logic [15:0] GAIN_RESET = 16'd2560;

  localparam logic signed [39:0] OUT_MAX = 40'sd8388607;
  localparam logic signed [39:0] OUT_MIN = -40'sd8388608;

  typedef struct packed {
    logic signed [24:0] ex;
    logic signed [24:0] ey;
    logic signed [16:0] eth;
    logic signed [23:0] vd;
    logic signed [23:0] wd;
    logic               neg_t;
    logic               neg_a;
  } cord_side_t;

  typedef struct packed {
    logic signed [27:0] p;
    logic signed [27:0] q;
    logic signed [16:0] eth;
    logic signed [23:0] vd;
    logic signed [23:0] wd;
  } sinc_side_t;

endpackage

/* sv/unicycle_tracking_control_unit.sv */
// Unicycle tracking control law, fully pipelined.
// Stages from start to out_valid: input prep, one CORDIC stage per iteration,
// two product stages, 12-stage sinc, three output stages.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset (rst_n low, synchronous) clears the valid line and sets both gains to 10.0.
// Depends on utc_pkg, utc_cordic and utc_sinc.
module unicycle_tracking_control_unit import utc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_current_x,
  input  logic signed [23:0] in_current_y,
  input  logic signed [15:0] in_current_heading,
  input  logic signed [23:0] in_target_x,
  input  logic signed [23:0] in_target_y,
  input  logic signed [15:0] in_target_heading,
  input  logic signed [23:0] in_feed_linear,
  input  logic signed [23:0] in_feed_angular,
  // result channel
  output logic               out_valid,
  output logic signed [23:0] out_drive_linear,
  output logic signed [23:0] out_drive_angular,
  output logic               out_clipped,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_idx_t           cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int LAT = CORDIC_STEPS + 18;

  // ---------------- configuration ----------------
  logic [15:0] gain_pos_r, gain_head_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_pos_r  <= GAIN_RESET;
      gain_head_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN_POSITION: gain_pos_r  <= cfg_data;
        CFG_GAIN_HEADING:  gain_head_r <= cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------- valid line ----------------
  // No stalls anywhere, so a plain shift line tracks every stage.
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start & ~busy};
  end

  assign out_valid = vld_r[LAT-1];

  // ---------------- stage 1: errors, heading wrap, angle reduction ----------------
  logic signed [16:0] eth_raw_c, eth_c, hsum_c;
  ang_t       zt_raw_c, za_raw_c, zt_c, za_c;
  logic       negt_c, nega_c;
  ang_t       zt_r, za_r;
  cord_side_t s1_r;

  always_comb begin
    eth_raw_c = 17'(in_current_heading) - 17'(in_target_heading);
    // difference spans less than two turns, one correction step suffices
    if (eth_raw_c > HEAD_PI)        eth_c = eth_raw_c - HEAD_TWO_PI;
    else if (eth_raw_c <= -HEAD_PI) eth_c = eth_raw_c + HEAD_TWO_PI;
    else                            eth_c = eth_raw_c;

    hsum_c   = 17'(in_current_heading) + 17'(in_target_heading);
    zt_raw_c = 28'(in_current_heading) <<< 11;  // Q.13 -> Q.24
    za_raw_c = 28'(hsum_c) <<< 10;              // mean heading in Q.24

    // fold into [-pi/2, pi/2]; sign of sin and cos flips
    negt_c = 1'b1;
    if (zt_raw_c > ANG_HALF_PI)       zt_c = zt_raw_c - ANG_PI;
    else if (zt_raw_c < -ANG_HALF_PI) zt_c = zt_raw_c + ANG_PI;
    else begin
      zt_c   = zt_raw_c;
      negt_c = 1'b0;
    end
    nega_c = 1'b1;
    if (za_raw_c > ANG_HALF_PI)       za_c = za_raw_c - ANG_PI;
    else if (za_raw_c < -ANG_HALF_PI) za_c = za_raw_c + ANG_PI;
    else begin
      za_c   = za_raw_c;
      nega_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    zt_r       <= zt_c;
    za_r       <= za_c;
    s1_r.ex    <= 25'(in_current_x) - 25'(in_target_x);
    s1_r.ey    <= 25'(in_current_y) - 25'(in_target_y);
    s1_r.eth   <= eth_c;
    s1_r.vd    <= in_feed_linear;
    s1_r.wd    <= in_feed_angular;
    s1_r.neg_t <= negt_c;
    s1_r.neg_a <= nega_c;
  end

  // ---------------- CORDIC stages ----------------
  trig_t ct_raw, st_raw, ca_raw, sa_raw;

  utc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_th (
    .clk(clk), .z_in(zt_r), .cos_out(ct_raw), .sin_out(st_raw)
  );

  utc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_al (
    .clk(clk), .z_in(za_r), .cos_out(ca_raw), .sin_out(sa_raw)
  );

  cord_side_t cd_r [0:CORDIC_STEPS-1];

  always_ff @(posedge clk) begin
    cd_r[0] <= s1_r;
    for (int i = 1; i < CORDIC_STEPS; i++) cd_r[i] <= cd_r[i-1];
  end

  // ---------------- products: projections of the position error ----------------
  cord_side_t cs;
  trig_t ct_c, st_c, ca_c, sa_c;
  logic signed [58:0] pa_r, pb_r, qa_r, qb_r;
  logic signed [16:0] m_eth_r;
  logic signed [23:0] m_vd_r, m_wd_r;

  assign cs   = cd_r[CORDIC_STEPS-1];
  assign ct_c = cs.neg_t ? -ct_raw : ct_raw;
  assign st_c = cs.neg_t ? -st_raw : st_raw;
  assign ca_c = cs.neg_a ? -ca_raw : ca_raw;
  assign sa_c = cs.neg_a ? -sa_raw : sa_raw;

  always_ff @(posedge clk) begin
    pa_r    <= cs.ex * ct_c;
    pb_r    <= cs.ey * st_c;
    qa_r    <= cs.ey * ca_c;
    qb_r    <= cs.ex * sa_c;
    m_eth_r <= cs.eth;
    m_vd_r  <= cs.vd;
    m_wd_r  <= cs.wd;
  end

  // p = exy*cos(psi-th), q = exy*sin(psi-alpha), Q.46 -> Q.16 rounded to nearest
  logic signed [59:0] psum_c, qsum_c;
  sinc_side_t sp_r;

  assign psum_c = 60'(pa_r) + 60'(pb_r) + 60'sd536870912;
  assign qsum_c = 60'(qa_r) - 60'(qb_r) + 60'sd536870912;

  always_ff @(posedge clk) begin
    sp_r.p   <= psum_c[57:30];
    sp_r.q   <= qsum_c[57:30];
    sp_r.eth <= m_eth_r;
    sp_r.vd  <= m_vd_r;
    sp_r.wd  <= m_wd_r;
  end

  // ---------------- sinc(eth/2) alongside a delay line ----------------
  sinc_t sinc_c;

  utc_sinc u_sinc (.clk(clk), .eth_in(sp_r.eth), .sinc_out(sinc_c));

  sinc_side_t sd_r [0:SINC_LAT-1];

  always_ff @(posedge clk) begin
    sd_r[0] <= sp_r;
    for (int i = 1; i < SINC_LAT; i++) sd_r[i] <= sd_r[i-1];
  end

  // ---------------- gain products ----------------
  sinc_side_t ds;
  logic signed [55:0] vs_p;
  logic signed [44:0] dv_p;
  logic signed [33:0] kt_p;
  logic signed [24:0] vs_r;
  logic signed [36:0] dv_r;
  logic signed [28:0] kt_r;
  logic signed [27:0] v_q_r;
  logic signed [23:0] v_vd_r, v_wd_r;

  assign ds   = sd_r[SINC_LAT-1];
  assign vs_p = 56'(ds.vd) * 56'($signed({1'b0, sinc_c})) + 56'sd536870912;
  assign dv_p = 45'(ds.p) * 45'($signed({1'b0, gain_pos_r})) + 45'sd128;
  assign kt_p = 34'($signed({1'b0, gain_head_r})) * 34'(ds.eth) + 34'sd16;

  always_ff @(posedge clk) begin
    vs_r   <= vs_p[54:30];
    dv_r   <= dv_p[44:8];
    kt_r   <= kt_p[33:5];
    v_q_r  <= ds.q;
    v_vd_r <= ds.vd;
    v_wd_r <= ds.wd;
  end

  // ---------------- cross term and linear command ----------------
  logic signed [52:0] vq_p;
  logic signed [36:0] vq_r;
  logic signed [37:0] lin_r;
  logic signed [28:0] q_kt_r;
  logic signed [23:0] q_wd_r;

  assign vq_p = 53'(vs_r) * 53'(v_q_r) + 53'sd32768;

  always_ff @(posedge clk) begin
    vq_r   <= vq_p[52:16];
    lin_r  <= 38'(v_vd_r) - 38'(dv_r);
    q_kt_r <= kt_r;
    q_wd_r <= v_wd_r;
  end

  // ---------------- angular sum, saturation, output register ----------------
  logic signed [39:0] lin_c, ang_c;
  logic signed [23:0] lin_sat_c, ang_sat_c;
  logic               clip_c;

  always_comb begin
    lin_c  = 40'(lin_r);
    ang_c  = 40'(q_wd_r) - 40'(q_kt_r) - 40'(vq_r);
    clip_c = 1'b0;
    if (lin_c > OUT_MAX) begin
      lin_sat_c = OUT_MAX[23:0];
      clip_c    = 1'b1;
    end else if (lin_c < OUT_MIN) begin
      lin_sat_c = OUT_MIN[23:0];
      clip_c    = 1'b1;
    end else begin
      lin_sat_c = lin_c[23:0];
    end
    if (ang_c > OUT_MAX) begin
      ang_sat_c = OUT_MAX[23:0];
      clip_c    = 1'b1;
    end else if (ang_c < OUT_MIN) begin
      ang_sat_c = OUT_MIN[23:0];
      clip_c    = 1'b1;
    end else begin
      ang_sat_c = ang_c[23:0];
    end
  end

  always_ff @(posedge clk) begin
    out_drive_linear  <= lin_sat_c;
    out_drive_angular <= ang_sat_c;
    out_clipped       <= clip_c;
  end

endmodule

/* sv/utc_cordic.sv */
// utc_cordic: fully pipelined rotation-mode CORDIC, one iteration per stage.
// Depends on utc_pkg (angle table, gain constant).
module utc_cordic import utc_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic  clk,
  input  ang_t  z_in,
  output trig_t cos_out,
  output trig_t sin_out
);

  trig_t x_r [0:STEPS-1];
  trig_t y_r [0:STEPS-1];
  ang_t  z_r [0:STEPS-2];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    trig_t xi, yi;
    ang_t  zi;
    if (i == 0) begin : g_first
      assign xi = INV_GAIN;
      assign yi = '0;
      assign zi = z_in;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (zi >= 0) begin
        x_r[i] <= xi - (yi >>> i);
        y_r[i] <= yi + (xi >>> i);
      end else begin
        x_r[i] <= xi + (yi >>> i);
        y_r[i] <= yi - (xi >>> i);
      end
    end

    if (i < STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        z_r[i] <= (zi >= 0) ? zi - ATAN_Q24[i] : zi + ATAN_Q24[i];
      end
    end
  end

  assign cos_out = x_r[STEPS-1];
  assign sin_out = y_r[STEPS-1];

endmodule

/* sv/utc_sinc.sv */
// utc_sinc: pipelined sinc(eth/2) series, Horner form, 12 stages.
// Depends on utc_pkg (divisors, reciprocals, Q.30 one).
module utc_sinc import utc_pkg::*; (
  input  logic               clk,
  input  logic signed [16:0] eth_in,
  output sinc_t              sinc_out
);

  logic [31:0] u0_r;
  logic [31:0] nm_r [0:SINC_TERMS-1];   // dividend
  logic [63:0] m_r  [0:SINC_TERMS-1];   // dividend * reciprocal
  logic [31:0] ud_r [0:SINC_TERMS-1];
  sinc_t       a_r  [0:SINC_TERMS-1];
  logic [31:0] ua_r [0:SINC_TERMS-2];
  logic [31:0] n_r  [1:SINC_TERMS-1];
  logic [31:0] un_r [1:SINC_TERMS-1];

  logic signed [33:0] sq_c;
  assign sq_c = eth_in * eth_in;

  always_ff @(posedge clk) begin
    u0_r <= {sq_c[29:0], 2'b00};   // u = (2*t)^2 with t in Q.15 -> Q.30
  end

  for (genvar k = 0; k < SINC_TERMS; k++) begin : g_term
    logic [31:0] num_c, uin_c, q0_c, r_c, qc_c;
    logic [38:0] qd_c;

    if (k == 0) begin : g_first
      assign num_c = u0_r;
      assign uin_c = u0_r;
    end else begin : g_horner
      logic [62:0] pr_c;
      assign pr_c = ua_r[k-1] * a_r[k-1];
      always_ff @(posedge clk) begin
        n_r[k]  <= pr_c[61:30];
        un_r[k] <= ua_r[k-1];
      end
      assign num_c = n_r[k];
      assign uin_c = un_r[k];
    end

    always_ff @(posedge clk) begin
      m_r[k]  <= num_c * SINC_RECIP[k];
      nm_r[k] <= num_c;
      ud_r[k] <= uin_c;
    end

    // estimate is low by at most one; a single compare fixes it
    assign q0_c = m_r[k][63:32];
    assign qd_c = q0_c * SINC_DIV[k];
    assign r_c  = nm_r[k] - qd_c[31:0];
    assign qc_c = (r_c >= 32'(SINC_DIV[k])) ? q0_c + 32'd1 : q0_c;

    always_ff @(posedge clk) begin
      a_r[k] <= ONE_Q30 - qc_c[30:0];
    end

    if (k < SINC_TERMS - 1) begin : g_u
      always_ff @(posedge clk) begin
        ua_r[k] <= ud_r[k];
      end
    end
  end

  assign sinc_out = a_r[SINC_TERMS-1];

endmodule

/* sv/utc_checker.sv */
// utc_checker: port-level checks for the tracking controller, bound to the top.
// Depends on utc_pkg and unicycle_tracking_control_unit.
module utc_checker import utc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [23:0] out_drive_linear,
  input logic signed [23:0] out_drive_angular,
  input logic               out_clipped,
  input logic               cfg_ready
);

  localparam int LAT = CORDIC_STEPS + 18;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready dropped");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("result missing after request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without request");

  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_drive_linear == 24'sh7FFFFF || out_drive_linear == 24'sh800000 ||
       out_drive_angular == 24'sh7FFFFF || out_drive_angular == 24'sh800000))
    else $error("clip flag without a saturated output");

endmodule

bind unicycle_tracking_control_unit utc_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_utc_checker (.*);
